// File: rtl/core/cpss_pkg.sv
// ----------------------------------------------------------------------------
// cpss_pkg
// Shared types, codes and fixed genetic code tables for the codon pair
// substitution statistics block.
// ----------------------------------------------------------------------------
package cpss_pkg;

    localparam int GROUP_COUNT = 25;
    localparam int GROUP_W     = 5;
    localparam int OUT_W       = 32;

    localparam logic [1:0] OP_COMPARE = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_BASE = 2'd1;
    localparam logic [1:0] ST_MISMATCH1 = 2'd2;
    localparam logic [1:0] ST_MISMATCH2 = 2'd3;

    localparam logic [2:0] OC_NONE       = 3'd0;
    localparam logic [2:0] OC_DIFFER     = 3'd1;
    localparam logic [2:0] OC_DIFF_CODON = 3'd2;
    localparam logic [2:0] OC_THIRD_SAME = 3'd3;
    localparam logic [2:0] OC_TRANSITION = 3'd4;
    localparam logic [2:0] OC_TRANSVERSE = 3'd5;

    localparam logic [7:0] ASCII_A = 8'h41;
    localparam logic [7:0] ASCII_C = 8'h43;
    localparam logic [7:0] ASCII_G = 8'h47;
    localparam logic [7:0] ASCII_T = 8'h54;

    localparam logic [1:0] BASE_T = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_A = 2'd2;
    localparam logic [1:0] BASE_G = 2'd3;

    localparam logic [GROUP_W-1:0] CODE_TABLE [64] = '{
        5'd15, 5'd15, 5'd11, 5'd11, 5'd17, 5'd17, 5'd17, 5'd17,
        5'd23, 5'd23, 5'd19, 5'd19, 5'd5,  5'd5,  5'd20, 5'd22,
        5'd12, 5'd12, 5'd12, 5'd12, 5'd16, 5'd16, 5'd16, 5'd16,
        5'd9,  5'd9,  5'd6,  5'd6,  5'd1,  5'd1,  5'd1,  5'd1,
        5'd10, 5'd10, 5'd10, 5'd14, 5'd21, 5'd21, 5'd21, 5'd21,
        5'd3,  5'd3,  5'd13, 5'd13, 5'd18, 5'd18, 5'd2,  5'd2,
        5'd24, 5'd24, 5'd24, 5'd24, 5'd0,  5'd0,  5'd0,  5'd0,
        5'd4,  5'd4,  5'd7,  5'd7,  5'd8,  5'd8,  5'd8,  5'd8
    };

    localparam logic [7:0] LETTER_TABLE [GROUP_COUNT] = '{
        8'h41, 8'h52, 8'h52, 8'h4E, 8'h44, 8'h43, 8'h51, 8'h45, 8'h47,
        8'h48, 8'h49, 8'h4C, 8'h4C, 8'h4B, 8'h4D, 8'h46, 8'h50, 8'h53,
        8'h53, 8'h2A, 8'h2A, 8'h54, 8'h57, 8'h59, 8'h56
    };

    typedef struct packed {
        logic capture;
        logic decode;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] code;
    } base_t;

    function automatic base_t base_code(input logic [7:0] b);
        base_t r;
        r.valid = 1'b1;
        r.code  = BASE_T;
        unique case (b)
            ASCII_T: r.code = BASE_T;
            ASCII_C: r.code = BASE_C;
            ASCII_A: r.code = BASE_A;
            ASCII_G: r.code = BASE_G;
            default: r.valid = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/codon_pair_substitution_stats.sv
// ----------------------------------------------------------------------------
// codon_pair_substitution_stats
// Codon pair substitution counter: compares codon pairs through the standard
// genetic code and keeps saturating global and per-group counters.
//
// Input channel (in_valid/in_ready) carries one op beat: compare a codon
// pair, read one group's counters, or clear all counters. Output channel
// (out_valid/out_ready) returns exactly one result beat per input beat.
// After input accept, the beat is decoded, then the counters are updated and
// out_valid is set. A new beat is accepted only after the update, as set by the
// three-step sequencer; in_ready is high only in its idle step.
// A finished result sits in the output register while the next beat is
// accepted and decoded; the counter update step waits while out_valid is
// high and out_ready is low, so no result is lost or overwritten.
// Reset clears all counters, the sequencer and out_valid at once; the block
// accepts a beat in the first cycle after reset is released.
// ----------------------------------------------------------------------------
module codon_pair_substitution_stats #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   op,
    input  logic [7:0]                   amino_first,
    input  logic [7:0]                   amino_second,
    input  logic [7:0]                   first_base_a,
    input  logic [7:0]                   first_base_b,
    input  logic [7:0]                   first_base_c,
    input  logic [7:0]                   second_base_a,
    input  logic [7:0]                   second_base_b,
    input  logic [7:0]                   second_base_c,
    input  logic [cpss_pkg::GROUP_W-1:0] read_group,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [2:0]                   outcome,
    output logic [cpss_pkg::GROUP_W-1:0] group,
    output logic [cpss_pkg::OUT_W-1:0]   total_compared,
    output logic [cpss_pkg::OUT_W-1:0]   identical_count,
    output logic [cpss_pkg::OUT_W-1:0]   diff_codon_count,
    output logic [cpss_pkg::OUT_W-1:0]   group_transitions,
    output logic [cpss_pkg::OUT_W-1:0]   group_transversions,
    output logic [cpss_pkg::OUT_W-1:0]   group_same
);
    import cpss_pkg::*;

    cmd_t cmd;

    cpss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    cpss_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .op                  (op),
        .amino_first         (amino_first),
        .amino_second        (amino_second),
        .first_base_a        (first_base_a),
        .first_base_b        (first_base_b),
        .first_base_c        (first_base_c),
        .second_base_a       (second_base_a),
        .second_base_b       (second_base_b),
        .second_base_c       (second_base_c),
        .read_group          (read_group),
        .status              (status),
        .outcome             (outcome),
        .group               (group),
        .total_compared      (total_compared),
        .identical_count     (identical_count),
        .diff_codon_count    (diff_codon_count),
        .group_transitions   (group_transitions),
        .group_transversions (group_transversions),
        .group_same          (group_same)
    );

`ifndef SYNTHESIS
    a_update_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (!out_valid || out_ready))
        else $error("counter update while result register is held");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat accepted during sequencing");

    a_error_not_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (outcome == OC_NONE))
        else $error("failed check reported a counted outcome");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && group >= GROUP_W'(GROUP_COUNT)) |->
        (group_transitions == '0 && group_transversions == '0 && group_same == '0))
        else $error("out of range group shows nonzero counters");
`endif

endmodule

// File: rtl/core/cpss_ctrl.sv
// ----------------------------------------------------------------------------
// cpss_ctrl
// Sequencer: capture a beat, decode it, update counters once the result
// register is free, and track the result valid flag.
// ----------------------------------------------------------------------------
module cpss_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output cpss_pkg::cmd_t cmd
);
    import cpss_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.update     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/cpss_datapath.sv
// ----------------------------------------------------------------------------
// cpss_datapath
// Input register, codon decode and check, saturating counters and the
// result register.
// ----------------------------------------------------------------------------
module cpss_datapath #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cpss_pkg::cmd_t                    cmd,
    input  logic [1:0]                        op,
    input  logic [7:0]                        amino_first,
    input  logic [7:0]                        amino_second,
    input  logic [7:0]                        first_base_a,
    input  logic [7:0]                        first_base_b,
    input  logic [7:0]                        first_base_c,
    input  logic [7:0]                        second_base_a,
    input  logic [7:0]                        second_base_b,
    input  logic [7:0]                        second_base_c,
    input  logic [cpss_pkg::GROUP_W-1:0]      read_group,
    output logic [1:0]                        status,
    output logic [2:0]                        outcome,
    output logic [cpss_pkg::GROUP_W-1:0]      group,
    output logic [cpss_pkg::OUT_W-1:0]        total_compared,
    output logic [cpss_pkg::OUT_W-1:0]        identical_count,
    output logic [cpss_pkg::OUT_W-1:0]        diff_codon_count,
    output logic [cpss_pkg::OUT_W-1:0]        group_transitions,
    output logic [cpss_pkg::OUT_W-1:0]        group_transversions,
    output logic [cpss_pkg::OUT_W-1:0]        group_same
);
    import cpss_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(
        input logic [COUNT_WIDTH-1:0] c,
        input logic                   en
    );
        logic [COUNT_WIDTH-1:0] r;
        r = c;
        if (en && c != CNT_MAX)
        begin
            r = c + COUNT_WIDTH'(1);
        end
        return r;
    endfunction

    logic [1:0]         op_reg;
    logic [7:0]         am1_reg;
    logic [7:0]         am2_reg;
    logic [7:0]         a1_reg;
    logic [7:0]         b1_reg;
    logic [7:0]         c1_reg;
    logic [7:0]         a2_reg;
    logic [7:0]         b2_reg;
    logic [7:0]         c2_reg;
    logic [GROUP_W-1:0] rg_reg;

    logic [1:0]         dec_status_reg;
    logic [1:0]         dec_status_next;
    logic [2:0]         dec_outcome_reg;
    logic [2:0]         dec_outcome_next;
    logic [GROUP_W-1:0] dec_group_reg;
    logic [GROUP_W-1:0] dec_group_next;
    logic               dec_clear_reg;

    logic [COUNT_WIDTH-1:0] total_reg;
    logic [COUNT_WIDTH-1:0] ident_reg;
    logic [COUNT_WIDTH-1:0] diff_reg;
    logic [COUNT_WIDTH-1:0] ts_reg   [GROUP_COUNT];
    logic [COUNT_WIDTH-1:0] tv_reg   [GROUP_COUNT];
    logic [COUNT_WIDTH-1:0] same_reg [GROUP_COUNT];

    logic [COUNT_WIDTH-1:0] total_next;
    logic [COUNT_WIDTH-1:0] ident_next;
    logic [COUNT_WIDTH-1:0] diff_next;
    logic [COUNT_WIDTH-1:0] ts_next;
    logic [COUNT_WIDTH-1:0] tv_next;
    logic [COUNT_WIDTH-1:0] same_next;

    logic [1:0]         status_reg;
    logic [2:0]         outcome_reg;
    logic [GROUP_W-1:0] group_reg;
    logic [OUT_W-1:0]   total_out_reg;
    logic [OUT_W-1:0]   ident_out_reg;
    logic [OUT_W-1:0]   diff_out_reg;
    logic [OUT_W-1:0]   ts_out_reg;
    logic [OUT_W-1:0]   tv_out_reg;
    logic [OUT_W-1:0]   same_out_reg;

    base_t              ba1;
    base_t              bb1;
    base_t              bc1;
    base_t              ba2;
    base_t              bb2;
    base_t              bc2;
    logic [GROUP_W-1:0] g1;
    logic [GROUP_W-1:0] g2;
    logic               in_range;
    logic [GROUP_W-1:0] gidx;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            am1_reg <= amino_first;
            am2_reg <= amino_second;
            a1_reg  <= first_base_a;
            b1_reg  <= first_base_b;
            c1_reg  <= first_base_c;
            a2_reg  <= second_base_a;
            b2_reg  <= second_base_b;
            c2_reg  <= second_base_c;
            rg_reg  <= read_group;
        end
    end

    always_comb
    begin
        ba1 = base_code(a1_reg);
        bb1 = base_code(b1_reg);
        bc1 = base_code(c1_reg);
        ba2 = base_code(a2_reg);
        bb2 = base_code(b2_reg);
        bc2 = base_code(c2_reg);
        g1  = CODE_TABLE[{ba1.code, bb1.code, bc1.code}];
        g2  = CODE_TABLE[{ba2.code, bb2.code, bc2.code}];

        dec_status_next  = ST_OK;
        dec_outcome_next = OC_NONE;
        dec_group_next   = '0;
        if (op_reg == OP_COMPARE)
        begin
            if (!(ba1.valid && bb1.valid && bc1.valid && ba2.valid && bb2.valid
                  && bc2.valid))
            begin
                dec_status_next = ST_BAD_BASE;
            end
            else
            begin
                dec_group_next = g2;
                if (am1_reg != LETTER_TABLE[g1])
                begin
                    dec_status_next = ST_MISMATCH1;
                end
                else if (am2_reg != LETTER_TABLE[g2])
                begin
                    dec_status_next = ST_MISMATCH2;
                end
                else if (am1_reg != am2_reg)
                begin
                    dec_outcome_next = OC_DIFFER;
                end
                else if (a1_reg != a2_reg || b1_reg != b2_reg)
                begin
                    dec_outcome_next = OC_DIFF_CODON;
                end
                else if (c1_reg == c2_reg)
                begin
                    dec_outcome_next = OC_THIRD_SAME;
                end
                else if ((bc1.code ^ bc2.code) == 2'b01)
                begin
                    dec_outcome_next = OC_TRANSITION;
                end
                else
                begin
                    dec_outcome_next = OC_TRANSVERSE;
                end
            end
        end
        else if (op_reg != OP_CLEAR)
        begin
            dec_group_next = rg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            dec_status_reg  <= dec_status_next;
            dec_outcome_reg <= dec_outcome_next;
            dec_group_reg   <= dec_group_next;
            dec_clear_reg   <= (op_reg == OP_CLEAR);
        end
    end

    always_comb
    begin
        in_range   = (dec_group_reg < GROUP_W'(GROUP_COUNT));
        gidx       = in_range ? dec_group_reg : '0;
        total_next = sat_inc(total_reg, dec_outcome_reg != OC_NONE);
        ident_next = sat_inc(ident_reg, dec_outcome_reg != OC_NONE
                                        && dec_outcome_reg != OC_DIFFER);
        diff_next  = sat_inc(diff_reg, dec_outcome_reg == OC_DIFF_CODON);
        same_next  = sat_inc(same_reg[gidx], dec_outcome_reg == OC_THIRD_SAME
                                             || dec_outcome_reg == OC_TRANSITION
                                             || dec_outcome_reg == OC_TRANSVERSE);
        ts_next    = sat_inc(ts_reg[gidx], dec_outcome_reg == OC_TRANSITION);
        tv_next    = sat_inc(tv_reg[gidx], dec_outcome_reg == OC_TRANSVERSE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            ident_reg <= '0;
            diff_reg  <= '0;
            for (int i = 0; i < GROUP_COUNT; i++)
            begin
                ts_reg[i]   <= '0;
                tv_reg[i]   <= '0;
                same_reg[i] <= '0;
            end
        end
        else if (cmd.update)
        begin
            if (dec_clear_reg)
            begin
                total_reg <= '0;
                ident_reg <= '0;
                diff_reg  <= '0;
                for (int i = 0; i < GROUP_COUNT; i++)
                begin
                    ts_reg[i]   <= '0;
                    tv_reg[i]   <= '0;
                    same_reg[i] <= '0;
                end
            end
            else
            begin
                total_reg      <= total_next;
                ident_reg      <= ident_next;
                diff_reg       <= diff_next;
                ts_reg[gidx]   <= ts_next;
                tv_reg[gidx]   <= tv_next;
                same_reg[gidx] <= same_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            status_reg  <= dec_status_reg;
            outcome_reg <= dec_outcome_reg;
            group_reg   <= dec_group_reg;
            if (dec_clear_reg)
            begin
                total_out_reg <= '0;
                ident_out_reg <= '0;
                diff_out_reg  <= '0;
                ts_out_reg    <= '0;
                tv_out_reg    <= '0;
                same_out_reg  <= '0;
            end
            else
            begin
                total_out_reg <= OUT_W'(total_next);
                ident_out_reg <= OUT_W'(ident_next);
                diff_out_reg  <= OUT_W'(diff_next);
                ts_out_reg    <= in_range ? OUT_W'(ts_next) : '0;
                tv_out_reg    <= in_range ? OUT_W'(tv_next) : '0;
                same_out_reg  <= in_range ? OUT_W'(same_next) : '0;
            end
        end
    end

    assign status              = status_reg;
    assign outcome             = outcome_reg;
    assign group               = group_reg;
    assign total_compared      = total_out_reg;
    assign identical_count     = ident_out_reg;
    assign diff_codon_count    = diff_out_reg;
    assign group_transitions   = ts_out_reg;
    assign group_transversions = tv_out_reg;
    assign group_same          = same_out_reg;

endmodule
